// ===== sv/mac_association_table_top_assert.svh =====
// assertion macros for the association table
// expects clk and rst in the scope of each use
`ifndef MAC_ASSOCIATION_TABLE_TOP_ASSERT_SVH
`define MAC_ASSOCIATION_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define MAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mat_pkg.sv =====
// shared types and constants of the association table
// no dependencies
`timescale 1ns / 1ps

package mat_pkg;

  localparam int MAT_ENTRIES = 16;
  localparam logic [3:0] MAT_EMPTY_KIND = 4'hf;
  localparam logic [1:0] MAT_LIFE_FULL = 2'd3;

  typedef enum logic [2:0] {
    MODE_ADD        = 3'd0,
    MODE_ADD_STAMP  = 3'd1,
    MODE_FIND_SHORT = 3'd2,
    MODE_FIND_LONG  = 3'd3,
    MODE_TICK       = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] laddr;
    logic [15:0] saddr;
    logic [1:0]  life;
    logic [31:0] stamp;
    logic [31:0] pending;
  } entry_t;

  localparam entry_t MAT_EMPTY_ENTRY = '{
    kind: MAT_EMPTY_KIND, laddr: 64'd0, saddr: 16'd0,
    life: 2'd0, stamp: 32'd0, pending: 32'd0
  };

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

// ===== sv/mat_mem.sv =====
// entry memory with one read and one write port, registered read
// per-entry valid bits give the empty reset value; uses mat_pkg
`timescale 1ns / 1ps

module mat_mem import mat_pkg::*; #(
  parameter int ENTRIES = MAT_ENTRIES,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  mem_ctl_t      ctl,
  input  logic [IW-1:0] rd_addr,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  output entry_t        rd_data
);

  entry_t             mem [ENTRIES];
  entry_t             rd_q;
  logic               rd_vld;
  logic [ENTRIES-1:0] vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : MAT_EMPTY_ENTRY;

endmodule

// ===== sv/mat_ctrl.sv =====
// scan sequencer: reads entries in order, matches, writes back, reports
// uses mat_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "mac_association_table_top_assert.svh"

module mat_ctrl import mat_pkg::*; #(
  parameter int ENTRIES = MAT_ENTRIES,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    mode,
  input  logic [63:0]   long_addr,
  input  logic [15:0]   short_addr,
  input  logic [3:0]    dev_kind,
  input  logic [31:0]   stamp_now,
  input  logic [31:0]   stamp_next,
  input  logic [31:0]   tick_count,
  output logic          done,
  output logic          status,
  output logic          found,
  output logic [3:0]    slot,
  output logic [3:0]    kind_out,
  output logic [63:0]   long_out,
  output logic [31:0]   stamp_out,
  output logic [31:0]   pending_out,
  output logic [1:0]    life_out,
  output mem_ctl_t      mem_ctl,
  output logic [IW-1:0] rd_addr,
  output logic [IW-1:0] wr_addr,
  output entry_t        wr_data,
  input  entry_t        rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CLEAR} state_t;

  state_t        state;
  logic [CW-1:0] rd_cnt, cnt_next;
  logic          evl, evl_next;
  logic [IW-1:0] ev_idx, ev_idx_next;
  logic          have_empty, empty_next;
  logic [IW-1:0] emp_idx, emp_idx_next;

  logic [2:0]    req_mode;
  logic [63:0]   req_long;
  logic [15:0]   req_short;
  logic [3:0]    req_kind;
  logic [31:0]   req_now;
  logic [31:0]   req_next;
  logic [31:0]   req_tick;

  mode_t         md;
  logic          stamped, ev_empty, long_hit, short_hit, last, issue;
  logic          fin, res_status, res_found, res_rep;
  logic [IW-1:0] res_idx;
  entry_t        fresh, refresh, aged;

  assign busy     = (state != S_IDLE);
  assign md       = mode_t'(req_mode);
  assign stamped  = (md == MODE_ADD_STAMP);
  assign ev_empty = (rd_data.kind == MAT_EMPTY_KIND);
  assign long_hit  = !ev_empty && (rd_data.laddr == req_long);
  assign short_hit = !ev_empty && (rd_data.saddr == req_short);
  assign last     = (ev_idx == IW'(ENTRIES - 1));
  assign issue    = (rd_cnt < CW'(ENTRIES));
  assign rd_addr  = rd_cnt[IW-1:0];

  always_comb begin
    fresh = '{kind: req_kind, laddr: req_long, saddr: req_short, life: MAT_LIFE_FULL,
              stamp: stamped ? req_now : 32'd0, pending: stamped ? req_next : 32'd0};
    refresh = rd_data;
    refresh.kind  = req_kind;
    refresh.laddr = req_long;
    refresh.saddr = req_short;
    refresh.life  = MAT_LIFE_FULL;
    if (stamped) begin
      refresh.stamp   = req_now;
      refresh.pending = req_next;
    end
    aged = rd_data;
    aged.stamp = (rd_data.stamp < rd_data.pending) ? rd_data.pending
                                                   : rd_data.stamp + req_tick;
    aged.pending = 32'd0;
  end

  always_comb begin
    mem_ctl      = '0;
    wr_addr      = ev_idx;
    wr_data      = rd_data;
    fin          = 1'b0;
    res_status   = 1'b0;
    res_found    = 1'b0;
    res_rep      = 1'b0;
    res_idx      = ev_idx;
    cnt_next     = rd_cnt;
    evl_next     = 1'b0;
    ev_idx_next  = ev_idx;
    empty_next   = have_empty;
    emp_idx_next = emp_idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cnt_next   = '0;
          empty_next = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          mem_ctl.rd_en = 1'b1;
          cnt_next      = rd_cnt + CW'(1);
          evl_next      = 1'b1;
          ev_idx_next   = rd_cnt[IW-1:0];
        end
        if (evl) begin
          case (md) inside
            MODE_ADD, MODE_ADD_STAMP: begin
              if (long_hit) begin
                mem_ctl.wr_en = 1'b1;
                wr_data       = refresh;
                fin           = 1'b1;
              end else if (short_hit) begin
                res_status = 1'b1;
                fin        = 1'b1;
              end else begin
                if (ev_empty && !have_empty) begin
                  empty_next   = 1'b1;
                  emp_idx_next = ev_idx;
                end
                if (last) begin
                  fin = 1'b1;
                  if (empty_next) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = emp_idx_next;
                    wr_data       = fresh;
                    res_idx       = emp_idx_next;
                  end else begin
                    res_status = 1'b1;
                    res_idx    = '0;
                  end
                end
              end
            end
            MODE_FIND_SHORT, MODE_FIND_LONG: begin
              if ((md == MODE_FIND_SHORT) ? short_hit : long_hit) begin
                fin       = 1'b1;
                res_found = 1'b1;
                res_rep   = 1'b1;
              end else if (last) begin
                fin     = 1'b1;
                res_idx = '0;
              end
            end
            MODE_TICK: begin
              if (!ev_empty) begin
                mem_ctl.wr_en = 1'b1;
                wr_data       = aged;
              end
              fin     = last;
              res_idx = '0;
            end
            default: begin
              fin     = 1'b1;
              res_idx = '0;
            end
          endcase
        end
        if (fin) begin
          evl_next = 1'b0;
        end
      end
      S_CLEAR: begin
        mem_ctl.clr = 1'b1;
        fin         = 1'b1;
        res_idx     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      evl   <= 1'b0;
    end else begin
      done       <= fin;
      rd_cnt     <= cnt_next;
      evl        <= evl_next;
      ev_idx     <= ev_idx_next;
      have_empty <= empty_next;
      emp_idx    <= emp_idx_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_mode   <= mode;
            req_long   <= long_addr;
            req_short  <= short_addr;
            req_kind   <= dev_kind;
            req_now    <= stamp_now;
            req_next   <= stamp_next;
            req_tick   <= tick_count;
            state      <= (mode_t'(mode) == MODE_CLEAR) ? S_CLEAR : S_SCAN;
          end
        end
        S_SCAN, S_CLEAR: begin
          if (fin) begin
            state       <= S_IDLE;
            status      <= res_status;
            found       <= res_found;
            slot        <= 4'(res_idx);
            kind_out    <= res_rep ? rd_data.kind : 4'd0;
            long_out    <= res_rep ? rd_data.laddr : 64'd0;
            stamp_out   <= res_rep ? rd_data.stamp : 32'd0;
            pending_out <= res_rep ? rd_data.pending : 32'd0;
            life_out    <= res_rep ? rd_data.life : 2'd0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // write-back never hits the entry being read in the same cycle
  `MAT_ASSERT_SAME(a_rw_apart, mem_ctl.wr_en && mem_ctl.rd_en, wr_addr != rd_addr,
                   "write and read of the same entry in one cycle")
  `MAT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not start")
  `MAT_ASSERT_SAME(a_done_idle, done, state == S_IDLE, "result strobed while still working")
  `MAT_ASSERT_SAME(a_found_ok, done && found, !status, "find result carries add status")

endmodule

// ===== sv/mac_association_table_top.sv =====
// channel      | signals                                   | handshake
// request      | mode long_addr short_addr dev_kind        | start && !busy
//              | stamp_now stamp_next tick_count           |
// result       | status found slot kind_out long_out       | done, one cycle
//              | stamp_out pending_out life_out            |
// add, find and tick scan the table through the single memory read port, one
// entry per cycle; an add or a find ends its scan early on a hit, and clear
// resets the valid bits without a scan.
// a new request is taken in the cycle done is high; results cannot be stalled.
// rst is synchronous; the table reads empty right after reset, no clearing pass.
// top level: joins the scan sequencer (mat_ctrl) and the entry memory (mat_mem)
`timescale 1ns / 1ps

module mac_association_table_top import mat_pkg::*; #(
  parameter int ENTRIES = MAT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [63:0] long_addr,
  input  logic [15:0] short_addr,
  input  logic [3:0]  dev_kind,
  input  logic [31:0] stamp_now,
  input  logic [31:0] stamp_next,
  input  logic [31:0] tick_count,
  output logic        done,
  output logic        status,
  output logic        found,
  output logic [3:0]  slot,
  output logic [3:0]  kind_out,
  output logic [63:0] long_out,
  output logic [31:0] stamp_out,
  output logic [31:0] pending_out,
  output logic [1:0]  life_out
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  mem_ctl_t      mem_ctl;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;

  mat_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .long_addr   (long_addr),
    .short_addr  (short_addr),
    .dev_kind    (dev_kind),
    .stamp_now   (stamp_now),
    .stamp_next  (stamp_next),
    .tick_count  (tick_count),
    .done        (done),
    .status      (status),
    .found       (found),
    .slot        (slot),
    .kind_out    (kind_out),
    .long_out    (long_out),
    .stamp_out   (stamp_out),
    .pending_out (pending_out),
    .life_out    (life_out),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data)
  );

  mat_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

// ===== bench/mac_association_table_checker.sv =====
// checker for the association table: tracks requests and results at the ports,
// keeps a shadow table to predict each result and compares it field by field
// depends on mat_pkg
`timescale 1ns / 1ps

module mac_association_table_checker import mat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  mode,
  input  logic [63:0] long_addr,
  input  logic [15:0] short_addr,
  input  logic [3:0]  dev_kind,
  input  logic [31:0] stamp_now,
  input  logic [31:0] stamp_next,
  input  logic [31:0] tick_count,
  input  logic        done,
  input  logic        status,
  input  logic        found,
  input  logic [3:0]  slot,
  input  logic [3:0]  kind_out,
  input  logic [63:0] long_out,
  input  logic [31:0] stamp_out,
  input  logic [31:0] pending_out,
  input  logic [1:0]  life_out,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic        status;
    logic        found;
    logic [3:0]  slot;
    logic [3:0]  kind;
    logic [63:0] laddr;
    logic [31:0] stamp;
    logic [31:0] pending;
    logic [1:0]  life;
  } reply_t;

  entry_t shadow [MAT_ENTRIES];
  reply_t awaited_replies [$];
  reply_t want;
  int fail_count = 0;

  function automatic void store_entry(input int idx, input logic [3:0] dt,
                                      input logic [63:0] la, input logic [15:0] sa,
                                      input bit stamped, input bit fresh,
                                      input logic [31:0] sn, input logic [31:0] sx);
    shadow[idx].kind = dt;
    shadow[idx].laddr = la;
    shadow[idx].saddr = sa;
    shadow[idx].life = MAT_LIFE_FULL;
    if (stamped) begin
      shadow[idx].stamp = sn;
      shadow[idx].pending = sx;
    end else if (fresh) begin
      shadow[idx].stamp = '0;
      shadow[idx].pending = '0;
    end
  endfunction

  // applies one request to the shadow table and returns the result it gives
  function automatic reply_t association_reply(
    input logic [2:0] md, input logic [63:0] la, input logic [15:0] sa,
    input logic [3:0] dt, input logic [31:0] sn, input logic [31:0] sx,
    input logic [31:0] tc);
    reply_t r;
    bit hit;
    bit stamped;
    r = '0;
    hit = 0;
    stamped = (md == MODE_ADD_STAMP);
    case (md)
      MODE_ADD, MODE_ADD_STAMP: begin
        for (int i = 0; i < MAT_ENTRIES; i++) begin
          if (!hit && shadow[i].kind != MAT_EMPTY_KIND) begin
            if (shadow[i].laddr == la) begin
              store_entry(i, dt, la, sa, stamped, 0, sn, sx);
              r.slot = i[3:0];
              hit = 1;
            end else if (shadow[i].saddr == sa) begin
              r.status = 1'b1;
              r.slot = i[3:0];
              hit = 1;
            end
          end
        end
        for (int i = 0; i < MAT_ENTRIES; i++) begin
          if (!hit && shadow[i].kind == MAT_EMPTY_KIND) begin
            store_entry(i, dt, la, sa, stamped, 1, sn, sx);
            r.slot = i[3:0];
            hit = 1;
          end
        end
        if (!hit) r.status = 1'b1;
      end
      MODE_FIND_SHORT, MODE_FIND_LONG: begin
        for (int i = 0; i < MAT_ENTRIES; i++) begin
          if (!hit && shadow[i].kind != MAT_EMPTY_KIND &&
              ((md == MODE_FIND_SHORT && shadow[i].saddr == sa) ||
               (md == MODE_FIND_LONG && shadow[i].laddr == la))) begin
            r.found = 1'b1;
            r.slot = i[3:0];
            r.kind = shadow[i].kind;
            r.laddr = shadow[i].laddr;
            r.stamp = shadow[i].stamp;
            r.pending = shadow[i].pending;
            r.life = shadow[i].life;
            hit = 1;
          end
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < MAT_ENTRIES; i++) begin
          if (shadow[i].kind != MAT_EMPTY_KIND) begin
            if (shadow[i].stamp < shadow[i].pending) shadow[i].stamp = shadow[i].pending;
            else shadow[i].stamp = shadow[i].stamp + tc;
            shadow[i].pending = '0;
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < MAT_ENTRIES; i++) shadow[i] = MAT_EMPTY_ENTRY;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAT_ENTRIES; i++) shadow[i] = MAT_EMPTY_ENTRY;
      awaited_replies.delete();
    end else begin
      if (done) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t ns: result with no request outstanding, expected none, actual slot %0h",
                   $time, slot);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          compare_field("status", 64'(want.status), 64'(status));
          compare_field("found", 64'(want.found), 64'(found));
          compare_field("slot", 64'(want.slot), 64'(slot));
          compare_field("kind_out", 64'(want.kind), 64'(kind_out));
          compare_field("long_out", want.laddr, long_out);
          compare_field("stamp_out", 64'(want.stamp), 64'(stamp_out));
          compare_field("pending_out", 64'(want.pending), 64'(pending_out));
          compare_field("life_out", 64'(want.life), 64'(life_out));
        end
      end
      if (start && !busy)
        awaited_replies.push_back(association_reply(mode, long_addr, short_addr, dev_kind,
                                                    stamp_now, stamp_next, tick_count));
    end
    errors <= fail_count;
    outstanding <= awaited_replies.size();
  end

endmodule

// ===== bench/mac_association_table_top_tb.sv =====
// testbench top for the association table: drives directed and random requests
// with random gaps and reports the verdict from the checker's failure count
// depends on mat_pkg, mac_association_table_top and mac_association_table_checker
`timescale 1ns / 1ps

module mac_association_table_top_tb import mat_pkg::*; ();

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int POOL = 24;
  localparam int RANDOM_REQUESTS = 1680;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  mode;
  logic [63:0] long_addr;
  logic [15:0] short_addr;
  logic [3:0]  dev_kind;
  logic [31:0] stamp_now;
  logic [31:0] stamp_next;
  logic [31:0] tick_count;
  logic        done;
  logic        status;
  logic        found;
  logic [3:0]  slot;
  logic [3:0]  kind_out;
  logic [63:0] long_out;
  logic [31:0] stamp_out;
  logic [31:0] pending_out;
  logic [1:0]  life_out;
  int          errors;
  int          outstanding;

  logic [63:0] pool_long [POOL];
  logic [15:0] pool_short [POOL];

  always #6 clk = ~clk;

  mac_association_table_top dut (.*);

  mac_association_table_checker u_check (.*);

  task automatic issue(input logic [2:0] md, input logic [63:0] la, input logic [15:0] sa,
                       input logic [3:0] dt, input logic [31:0] sn, input logic [31:0] sx,
                       input logic [31:0] tc, input int gap);
    mode <= md;
    long_addr <= la;
    short_addr <= sa;
    dev_kind <= dt;
    stamp_now <= sn;
    stamp_next <= sx;
    tick_count <= tc;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every request has its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    int r;
    int pick;
    bit burst;
    logic [2:0] md;
    logic [63:0] la;
    logic [15:0] sa;
    logic [31:0] sn;
    logic [31:0] sx;
    logic [31:0] tc;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_ADD;
    long_addr <= '0;
    short_addr <= '0;
    dev_kind <= '0;
    stamp_now <= '0;
    stamp_next <= '0;
    tick_count <= '0;
    burst = 0;
    for (n = 0; n < POOL; n++) begin
      pool_long[n] = {$urandom, $urandom};
      pool_short[n] = 16'($urandom);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    issue(MODE_FIND_SHORT, '0, 16'h0000, 4'd0, '0, '0, '0, $urandom_range(0, 10));
    issue(MODE_FIND_LONG, '1, 16'hffff, 4'd0, '0, '0, '0, $urandom_range(0, 10));
    issue(MODE_ADD, '0, 16'h0000, 4'd0, '1, '1, '0, $urandom_range(0, 10));
    issue(MODE_ADD_STAMP, '1, 16'hffff, 4'd14, '1, '0, '0, $urandom_range(0, 10));
    // refresh with new stamps, then refresh keeping stamps
    issue(MODE_ADD_STAMP, '0, 16'h1234, 4'd7, 32'd5, 32'd100, '0, $urandom_range(0, 10));
    issue(MODE_ADD, '1, 16'hffff, 4'd3, 32'd9, 32'd9, '0, $urandom_range(0, 10));
    // short address already taken by another device
    issue(MODE_ADD, 64'd1, 16'hffff, 4'd2, '0, '0, '0, $urandom_range(0, 10));
    issue(MODE_FIND_SHORT, 64'd1, 16'h1234, 4'd0, '0, '0, '0, $urandom_range(0, 10));
    issue(MODE_FIND_LONG, '1, 16'h0000, 4'd0, '0, '0, '0, $urandom_range(0, 10));
    // one entry adopts its pending stamp, the other wraps
    issue(MODE_TICK, '0, '0, 4'd0, '0, '0, '1, $urandom_range(0, 10));
    issue(MODE_TICK, '0, '0, 4'd0, '0, '0, 32'd1, $urandom_range(0, 10));
    issue(MODE_FIND_LONG, '0, '0, 4'd0, '0, '0, '0, $urandom_range(0, 10));
    // empty marker as device type
    issue(MODE_ADD, 64'ha5a5_a5a5_a5a5_a5a5, 16'h5a5a, MAT_EMPTY_KIND, '0, '0, '0,
          $urandom_range(0, 10));
    issue(MODE_FIND_LONG, 64'ha5a5_a5a5_a5a5_a5a5, 16'h5a5a, 4'd0, '0, '0, '0,
          $urandom_range(0, 10));
    issue(MODE_SPARE_A, '1, 16'h0001, 4'd1, 32'd7, 32'd7, 32'd7, $urandom_range(0, 10));
    issue(MODE_SPARE_B, '1, '1, 4'd14, '1, '1, '1, $urandom_range(0, 10));
    issue(MODE_FIND_SHORT, '0, 16'hffff, 4'd0, '0, '0, '0, $urandom_range(0, 10));
    issue(MODE_CLEAR, '0, '0, 4'd0, '0, '0, '0, $urandom_range(0, 10));
    issue(MODE_FIND_LONG, '0, '0, 4'd0, '0, '0, '0, 1);
    drain();

    // random: mostly known devices so refreshes, conflicts and full table occur
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n % 240 == 239) drain();
      r = $urandom_range(0, 99);
      if (r < 32) md = MODE_ADD;
      else if (r < 52) md = MODE_ADD_STAMP;
      else if (r < 66) md = MODE_FIND_SHORT;
      else if (r < 80) md = MODE_FIND_LONG;
      else if (r < 97) md = MODE_TICK;
      else md = MODE_CLEAR;
      pick = $urandom_range(0, POOL - 1);
      la = pool_long[pick];
      sa = pool_short[pick];
      r = $urandom_range(0, 9);
      if (r == 0) la = {$urandom, $urandom};
      else if (r == 1) begin
        la = {$urandom, $urandom};
        sa = 16'($urandom);
      end
      sn = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom;
      sx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom;
      case ($urandom_range(0, 7))
        0: tc = '0;
        1: tc = '1;
        2, 3: tc = $urandom_range(1, 1000);
        default: tc = $urandom;
      endcase
      issue(md, la, sa, 4'($urandom_range(0, 14)), sn, sx, tc,
            burst ? 0 : $urandom_range(0, 10));
    end
    drain();
    repeat (MAT_ENTRIES + 4) @(posedge clk);
    if (errors == 0) $display("[mac_association_table_top] OK");
    else $display("[mac_association_table_top] ERROR");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[mac_association_table_top] ERROR");
    $finish;
  end

endmodule
